// ===== rtl/core/sbfd_pkg.sv =====
// sbfd_pkg: types and constants shared by the sbus frame decoder
// no dependencies
package sbfd_pkg;

  localparam int unsigned FrameLen  = 24;
  localparam int unsigned NumCh     = 15;
  localparam int unsigned ChBits    = 11;
  localparam int unsigned PosBits   = 5;
  localparam int unsigned DataBytes = FrameLen - 2;
  localparam int unsigned DataBits  = DataBytes * 8;

  localparam logic [PosBits-1:0] PosMax  = 5'd31;
  localparam logic [PosBits-1:0] PosLast = 5'd23;
  localparam logic [PosBits-1:0] PosEnd  = 5'd24;

  localparam logic [7:0] HeaderByte = 8'h0F;
  localparam logic [7:0] FlagsOk    = 8'h00;

  localparam logic [11:0] CenterStick = 12'd1024;
  localparam logic [11:0] CenterKnob  = 12'd240;

  localparam logic [10:0] RawLow  = 11'd240;
  localparam logic [10:0] RawHigh = 11'd1807;
  localparam logic [10:0] RawMid  = 11'd1024;

  localparam logic [3:0] ChFirst    = 4'd1;
  localparam logic [3:0] ChLastStk  = 4'd4;
  localparam logic [3:0] ChLastKnob = 4'd6;
  localparam logic [3:0] ChFirstSw  = 4'd7;
  localparam logic [3:0] ChMidSw    = 4'd9;
  localparam logic [3:0] ChLastSw   = 4'd10;
  localparam logic [3:0] ChFinal    = 4'd15;

  localparam logic [1:0] SwNone = 2'd0;
  localparam logic [1:0] SwLow  = 2'd1;
  localparam logic [1:0] SwHigh = 2'd2;
  localparam logic [1:0] SwMid  = 2'd3;

  // frame hand-off from the byte collector to the channel emitter
  typedef struct packed {
    logic                load;
    logic [DataBits-1:0] data;
  } frame_t;

endpackage

// ===== rtl/core/sbfd_rx_if.sv =====
// sbfd_rx_if: receive byte channel, valid/ready handshake
// no dependencies
interface sbfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_begin;

  modport source (output valid, output rx_byte, output frame_begin, input ready);
  modport sink (input valid, input rx_byte, input frame_begin, output ready);
endinterface

// ===== rtl/core/sbfd_res_if.sv =====
// sbfd_res_if: decoded channel result channel, valid/ready handshake
// no dependencies
interface sbfd_res_if;
  logic               valid;
  logic               ready;
  logic [3:0]         channel_number;
  logic [10:0]        raw_value;
  logic signed [11:0] centered_value;
  logic [1:0]         switch_code;
  logic               last_channel;

  modport source (output valid, output channel_number, output raw_value,
                  output centered_value, output switch_code, output last_channel,
                  input ready);
  modport sink (input valid, input channel_number, input raw_value,
                input centered_value, input switch_code, input last_channel,
                output ready);
endinterface

// ===== rtl/core/sbfd_collect.sv =====
// sbfd_collect: byte position counter, frame buffer and frame check
// depends on sbfd_pkg
module sbfd_collect (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                frame_begin_i,
  output sbfd_pkg::frame_t    frame_o
);

  logic [sbfd_pkg::PosBits-1:0] pos_q, pos_d, pos_cur;
  logic [7:0] buf_q [sbfd_pkg::FrameLen];

  assign pos_cur = frame_begin_i ? '0 : pos_q;

  always_comb begin
    pos_d = pos_q;
    if (accept_i) begin
      pos_d = (pos_cur < sbfd_pkg::PosMax) ? pos_cur + 1'b1 : pos_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && (pos_cur < sbfd_pkg::PosEnd)) begin
      buf_q[pos_cur] <= rx_byte_i;
    end
  end

  // the flags byte is the one arriving now, the header is already stored
  assign frame_o.load = accept_i && (pos_cur == sbfd_pkg::PosLast) &&
                        (buf_q[0] == sbfd_pkg::HeaderByte) &&
                        (rx_byte_i == sbfd_pkg::FlagsOk);

  for (genvar i = 0; i < sbfd_pkg::DataBytes; i++) begin : g_data
    assign frame_o.data[8*i +: 8] = buf_q[i+1];
  end

endmodule

// ===== rtl/core/sbfd_emit.sv =====
// sbfd_emit: channel unpacking, centering, switch codes and result register
// depends on sbfd_pkg
module sbfd_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sbfd_pkg::frame_t   frame_i,
  output logic               busy_o,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [3:0]         channel_number_o,
  output logic [10:0]        raw_value_o,
  output logic signed [11:0] centered_value_o,
  output logic [1:0]         switch_code_o,
  output logic               last_channel_o
);

  logic                          active_q, active_d;
  logic [3:0]                    ch_q, ch_d;
  logic [sbfd_pkg::DataBits-1:0] sh_q, sh_d;
  logic [1:0]                    sw_q [4];
  logic                          valid_q, valid_d;
  logic [3:0]                    chn_q;
  logic [10:0]                   raw_q;
  logic signed [11:0]            cen_q;
  logic [1:0]                    code_q;
  logic                          last_q;

  logic              advance;
  logic [10:0]       raw;
  logic [11:0]       cen;
  logic              is_sw;
  logic [1:0]        sw_idx;
  logic [1:0]        sw_new;

  assign advance = active_q && (!valid_q || ready_i);
  assign raw     = sh_q[sbfd_pkg::ChBits-1:0];
  assign is_sw   = (ch_q >= sbfd_pkg::ChFirstSw) && (ch_q <= sbfd_pkg::ChLastSw);
  assign sw_idx  = 2'(ch_q - sbfd_pkg::ChFirstSw);

  always_comb begin
    if (ch_q <= sbfd_pkg::ChLastStk) begin
      cen = {1'b0, raw} - sbfd_pkg::CenterStick;
    end else if (ch_q <= sbfd_pkg::ChLastKnob) begin
      cen = {1'b0, raw} - sbfd_pkg::CenterKnob;
    end else begin
      cen = {1'b0, raw};
    end
  end

  always_comb begin
    sw_new = sw_q[sw_idx];
    if (raw == sbfd_pkg::RawLow) begin
      sw_new = sbfd_pkg::SwLow;
    end else if (raw == sbfd_pkg::RawHigh) begin
      sw_new = sbfd_pkg::SwHigh;
    end else if ((ch_q == sbfd_pkg::ChMidSw) && (raw == sbfd_pkg::RawMid)) begin
      sw_new = sbfd_pkg::SwMid;
    end
  end

  always_comb begin
    active_d = active_q;
    ch_d     = ch_q;
    sh_d     = sh_q;
    valid_d  = valid_q && !ready_i;
    if (frame_i.load) begin
      active_d = 1'b1;
      ch_d     = sbfd_pkg::ChFirst;
      sh_d     = frame_i.data;
    end else if (advance) begin
      active_d = (ch_q != sbfd_pkg::ChFinal);
      ch_d     = ch_q + 4'd1;
      sh_d     = sh_q >> sbfd_pkg::ChBits;
    end
    if (advance) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
      ch_q     <= sbfd_pkg::ChFirst;
      for (int i = 0; i < 4; i++) begin
        sw_q[i] <= sbfd_pkg::SwNone;
      end
    end else begin
      active_q <= active_d;
      valid_q  <= valid_d;
      ch_q     <= ch_d;
      if (advance && is_sw) begin
        sw_q[sw_idx] <= sw_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    if (advance) begin
      chn_q  <= ch_q;
      raw_q  <= raw;
      cen_q  <= cen;
      code_q <= is_sw ? sw_new : sbfd_pkg::SwNone;
      last_q <= (ch_q == sbfd_pkg::ChFinal);
    end
  end

  assign busy_o           = active_q;
  assign valid_o          = valid_q;
  assign channel_number_o = chn_q;
  assign raw_value_o      = raw_q;
  assign centered_value_o = cen_q;
  assign switch_code_o    = code_q;
  assign last_channel_o   = last_q;

endmodule

// ===== rtl/core/sbus_frame_decoder.sv =====
// sbus_frame_decoder: top level, byte collector feeding the channel emitter
// order: flags byte 23 of a good frame loads the emitter shift register, then channel
// results follow, one channel per cycle while the sink is ready, 15 results per frame
// throughput: one byte per cycle; the byte input is held off while the emitter
// still has channels of a frame left to produce
// reset: asynchronous active low, clears position, switch codes and result valid
// depends on sbfd_pkg, sbfd_rx_if, sbfd_res_if, sbfd_collect, sbfd_emit
module sbus_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbfd_rx_if.sink     rx_i,
  sbfd_res_if.source  res_o
);

  sbfd_pkg::frame_t frame;
  logic             emit_busy;
  logic             rx_accept;

  // bytes are held off only while channels of a good frame are still unpacked
  assign rx_i.ready = !emit_busy;
  assign rx_accept  = rx_i.valid && !emit_busy;

  // position counter, 24-byte buffer, header and flags check
  sbfd_collect u_collect (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (rx_accept),
    .rx_byte_i     (rx_i.rx_byte),
    .frame_begin_i (rx_i.frame_begin),
    .frame_o       (frame)
  );

  // walks the 22 data bytes 11 bits per word, output register parts the sides
  sbfd_emit u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .frame_i          (frame),
    .busy_o           (emit_busy),
    .valid_o          (res_o.valid),
    .ready_i          (res_o.ready),
    .channel_number_o (res_o.channel_number),
    .raw_value_o      (res_o.raw_value),
    .centered_value_o (res_o.centered_value),
    .switch_code_o    (res_o.switch_code),
    .last_channel_o   (res_o.last_channel)
  );

endmodule

// ===== rtl/core/sbfd_checker.sv =====
// sbfd_checker: port level checks of the sbus frame decoder, bound to the top
// depends on sbfd_pkg, sbus_frame_decoder
module sbfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rx_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [3:0]  channel_number_i,
  input logic [10:0] raw_value_i,
  input logic [1:0]  switch_code_i,
  input logic        last_channel_i
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(raw_value_i) &&
    $stable(channel_number_i))
    else $error("stalled result word changed");

  // channels of a frame follow each other with no gap
  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && !last_channel_i |=>
    res_valid_i && (channel_number_i == $past(channel_number_i) + 4'd1))
    else $error("channel sequence broken");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && last_channel_i |-> channel_number_i == sbfd_pkg::ChFinal)
    else $error("last flag on wrong channel");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && ((channel_number_i < sbfd_pkg::ChFirstSw) ||
                    (channel_number_i > sbfd_pkg::ChLastSw)) |->
    switch_code_i == sbfd_pkg::SwNone)
    else $error("switch code on non-switch channel");

  // bytes are held off while a frame is mid-drain
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !last_channel_i |-> !rx_ready_i)
    else $error("byte input open during frame drain");

endmodule

bind sbus_frame_decoder sbfd_checker u_sbfd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rx_ready_i       (rx_i.ready),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .channel_number_i (res_o.channel_number),
  .raw_value_i      (res_o.raw_value),
  .switch_code_i    (res_o.switch_code),
  .last_channel_i   (res_o.last_channel)
);
